FILE: rtl/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared constants, types and helper functions for the NMEA sentence parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsp_pkg;

  // Store geometry
  localparam int FIELD_SLOTS = 11;
  localparam int GGA_FIELDS  = 15;
  localparam int RMC_FIELDS  = 13;
  localparam int GSA_FIELDS  = 18;
  localparam int NUM_TYPES   = 3;

  localparam int MAX_GR      = (GGA_FIELDS > RMC_FIELDS) ? GGA_FIELDS : RMC_FIELDS;
  localparam int MAX_FIELDS  = (MAX_GR > GSA_FIELDS) ? MAX_GR : GSA_FIELDS;
  localparam int STORE_DEPTH = NUM_TYPES * MAX_FIELDS * FIELD_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FNUM_W      = $clog2(MAX_FIELDS + 1);
  // position also counts the two checksum digits, so it must reach 2
  localparam int POS_W       = $clog2(((FIELD_SLOTS > 3) ? FIELD_SLOTS : 3) + 1);

  // Sentence ID
  localparam int ID_LEN      = 5;
  localparam int ID_CNT_W    = $clog2(ID_LEN + 1);
  localparam logic [8*ID_LEN-1:0] ID_GGA = "GPGGA";
  localparam logic [8*ID_LEN-1:0] ID_RMC = "GPRMC";
  localparam logic [8*ID_LEN-1:0] ID_GSA = "GPGSA";

  // Character codes
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] HEX_DIGIT_BASE = 8'd48;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd55;

  // Opcodes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Sentence type codes
  localparam logic [1:0] TYPE_GGA = 2'd0;
  localparam logic [1:0] TYPE_RMC = 2'd1;
  localparam logic [1:0] TYPE_GSA = 2'd2;

  // Op queue between parser and store
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_ID,
    PH_FIELDS,
    PH_SUM
  } phase_e;

  // One queued store operation plus the result fields already known
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic              frame_valid;
    logic              done;
    logic [1:0]        done_type;
  } nsp_op_t;

  // Number of fields kept for a sentence type
  function automatic int fields_of(input logic [1:0] t);
    int n;
    n = GSA_FIELDS;
    if (t == TYPE_GGA) n = GGA_FIELDS;
    else if (t == TYPE_RMC) n = RMC_FIELDS;
    return n;
  endfunction

  // Flat store address of one character
  function automatic logic [ADDR_W-1:0] store_addr(input int t, input int f, input int p);
    int a;
    a = (t * MAX_FIELDS + f) * FIELD_SLOTS + p;
    return a[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/nsp_ram.sv
// ----------------------------------------------------------------------------
// nsp_ram
// Generic single-port RAM, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nsp_front.sv
// ----------------------------------------------------------------------------
// nsp_front
// Sentence parser: takes one item per cycle unless the op queue is full, runs
// the parse state and turns each item into one store op for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [1:0]       read_type_i,
  input  logic [4:0]       read_field_i,
  input  logic [3:0]       read_pos_i,
  input  logic             fifo_full_i,
  output logic             push_o,
  output nsp_pkg::nsp_op_t op_o
);

  nsp_pkg::phase_e                 phase_q, phase_d;
  logic [8*nsp_pkg::ID_LEN-1:0]    id_q, id_d;
  logic [nsp_pkg::ID_CNT_W-1:0]    id_len_q, id_len_d;
  logic                            overlong_q, overlong_d;
  logic [1:0]                      type_q, type_d;
  logic [nsp_pkg::FNUM_W-1:0]      fnum_q, fnum_d;
  logic [nsp_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [7:0]                      xor_q, xor_d;
  logic [7:0]                      sum_q, sum_d;
  logic [nsp_pkg::NUM_TYPES-1:0]   vflags_q, vflags_d;

  logic       accept;
  logic       put_en;
  logic [7:0] put_data;
  logic       put_ok;
  logic [7:0] hex_v;
  logic       sum_ok;

  assign accept     = in_valid_i && !fifo_full_i;
  assign in_stall_o = fifo_full_i;
  assign push_o     = accept;

  // store write is allowed only inside the kept fields and slots
  assign put_ok = (int'(fnum_q) < nsp_pkg::fields_of(type_q)) &&
                  (int'(pos_q) < nsp_pkg::FIELD_SLOTS);

  // hex digit value of the incoming byte, in the high nibble for the first digit
  always_comb begin
    if (rx_byte_i >= nsp_pkg::CH_ZERO && rx_byte_i <= nsp_pkg::CH_NINE) begin
      hex_v = rx_byte_i - nsp_pkg::HEX_DIGIT_BASE;
    end else begin
      hex_v = rx_byte_i - nsp_pkg::HEX_ALPHA_BASE;
    end
    if (pos_q == '0) begin
      hex_v = {hex_v[3:0], 4'h0};
    end
  end

  assign sum_ok = (sum_q == xor_q);

  // parse step and op build
  always_comb begin
    phase_d    = phase_q;
    id_d       = id_q;
    id_len_d   = id_len_q;
    overlong_d = overlong_q;
    type_d     = type_q;
    fnum_d     = fnum_q;
    pos_d      = pos_q;
    xor_d      = xor_q;
    sum_d      = sum_q;
    vflags_d   = vflags_q;
    put_en     = 1'b0;
    put_data   = 8'h00;
    op_o       = '0;

    if (accept) begin
      if (opcode_i == nsp_pkg::OP_READ) begin
        if (int'(read_type_i) < nsp_pkg::NUM_TYPES) begin
          op_o.frame_valid = vflags_q[read_type_i];
          op_o.rd_en = (read_field_i != 5'd0) &&
                       (int'(read_field_i) < nsp_pkg::fields_of(read_type_i)) &&
                       (int'(read_pos_i) < nsp_pkg::FIELD_SLOTS);
          op_o.addr  = nsp_pkg::store_addr(int'(read_type_i), int'(read_field_i),
                                           int'(read_pos_i));
        end
      end else begin
        unique case (phase_q)
          nsp_pkg::PH_WAIT: begin
            if (rx_byte_i == nsp_pkg::CH_DOLLAR) begin
              phase_d    = nsp_pkg::PH_ID;
              id_len_d   = '0;
              overlong_d = 1'b0;
              fnum_d     = nsp_pkg::FNUM_W'(1);
              pos_d      = '0;
              xor_d      = 8'h00;
              sum_d      = 8'h00;
            end
          end
          nsp_pkg::PH_ID: begin
            xor_d = xor_q ^ rx_byte_i;
            priority if (rx_byte_i == nsp_pkg::CH_COMMA) begin
              phase_d = nsp_pkg::PH_WAIT;
              pos_d   = '0;
              if (!overlong_q && int'(id_len_q) == nsp_pkg::ID_LEN) begin
                priority if (id_q == nsp_pkg::ID_GGA) begin
                  type_d  = nsp_pkg::TYPE_GGA;
                  phase_d = nsp_pkg::PH_FIELDS;
                end else if (id_q == nsp_pkg::ID_RMC) begin
                  type_d  = nsp_pkg::TYPE_RMC;
                  phase_d = nsp_pkg::PH_FIELDS;
                end else if (id_q == nsp_pkg::ID_GSA) begin
                  type_d  = nsp_pkg::TYPE_GSA;
                  phase_d = nsp_pkg::PH_FIELDS;
                end else begin
                  phase_d = nsp_pkg::PH_WAIT;
                end
              end
            end else if (int'(id_len_q) < nsp_pkg::ID_LEN) begin
              id_d     = {id_q[8*nsp_pkg::ID_LEN-9:0], rx_byte_i};
              id_len_d = id_len_q + nsp_pkg::ID_CNT_W'(1);
            end else begin
              overlong_d = 1'b1;
            end
          end
          nsp_pkg::PH_FIELDS: begin
            priority if (rx_byte_i == nsp_pkg::CH_COMMA) begin
              xor_d    = xor_q ^ rx_byte_i;
              put_en   = put_ok;
              put_data = 8'h00;
              if (int'(fnum_q) < nsp_pkg::fields_of(type_q)) begin
                fnum_d = fnum_q + nsp_pkg::FNUM_W'(1);
              end
              pos_d = '0;
            end else if (rx_byte_i == nsp_pkg::CH_STAR) begin
              put_en   = put_ok;
              put_data = 8'h00;
              pos_d    = '0;
              phase_d  = nsp_pkg::PH_SUM;
            end else begin
              xor_d = xor_q ^ rx_byte_i;
              if (int'(pos_q) < nsp_pkg::FIELD_SLOTS - 1) begin
                put_en   = put_ok;
                put_data = rx_byte_i;
                pos_d    = pos_q + nsp_pkg::POS_W'(1);
              end
            end
          end
          nsp_pkg::PH_SUM: begin
            if (int'(pos_q) >= 2) begin
              vflags_d[type_q] = sum_ok;
              op_o.frame_valid = sum_ok;
              op_o.done        = 1'b1;
              op_o.done_type   = type_q;
              phase_d          = nsp_pkg::PH_WAIT;
            end else begin
              sum_d = sum_q + hex_v;
              pos_d = pos_q + nsp_pkg::POS_W'(1);
            end
          end
          default: begin
            phase_d = nsp_pkg::PH_WAIT;
          end
        endcase
        op_o.wr_en = put_en;
        op_o.wdata = put_data;
        op_o.addr  = nsp_pkg::store_addr(int'(type_q), int'(fnum_q), int'(pos_q));
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= nsp_pkg::PH_WAIT;
      id_q       <= '0;
      id_len_q   <= '0;
      overlong_q <= 1'b0;
      type_q     <= nsp_pkg::TYPE_GGA;
      fnum_q     <= nsp_pkg::FNUM_W'(1);
      pos_q      <= '0;
      xor_q      <= 8'h00;
      sum_q      <= 8'h00;
      vflags_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      id_q       <= id_d;
      id_len_q   <= id_len_d;
      overlong_q <= overlong_d;
      type_q     <= type_d;
      fnum_q     <= fnum_d;
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      sum_q      <= sum_d;
      vflags_q   <= vflags_d;
    end
  end

endmodule

FILE: rtl/nsp_fifo.sv
// ----------------------------------------------------------------------------
// nsp_fifo
// Short op queue between the parser and the store back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nsp_pkg::nsp_op_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output nsp_pkg::nsp_op_t data_o
);

  nsp_pkg::nsp_op_t                 mem_q [nsp_pkg::FIFO_DEPTH];
  logic [nsp_pkg::FIFO_PTR_W-1:0]   wptr_q, wptr_d;
  logic [nsp_pkg::FIFO_PTR_W-1:0]   rptr_q, rptr_d;
  logic [nsp_pkg::FIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o  = (int'(cnt_q) == nsp_pkg::FIFO_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (int'(wptr_q) == nsp_pkg::FIFO_DEPTH - 1) ? '0 :
               wptr_q + nsp_pkg::FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (int'(rptr_q) == nsp_pkg::FIFO_DEPTH - 1) ? '0 :
               rptr_q + nsp_pkg::FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + nsp_pkg::FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - nsp_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/nsp_back.sv
// ----------------------------------------------------------------------------
// nsp_back
// Store back end: executes queued writes and reads on the frame store and
// drives the result channel through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_valid_i,
  input  nsp_pkg::nsp_op_t op_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_char_o,
  output logic             frame_valid_o,
  output logic             sentence_done_o,
  output logic [1:0]       done_type_o
);

  logic             s1_valid_q, s1_valid_d;
  nsp_pkg::nsp_op_t s1_op_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       rchar_q;
  logic             fv_q;
  logic             done_q;
  logic [1:0]       dtype_q;

  logic       out_load;
  logic       s1_move;
  logic [7:0] rdata;

  assign out_load = !out_valid_q || !out_stall_i;
  assign s1_move  = s1_valid_q && out_load;
  assign pop_o    = fifo_valid_i && (!s1_valid_q || out_load);

  nsp_ram #(
    .WIDTH (8),
    .DEPTH (nsp_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pop_o && op_i.wr_en),
    .re_i    (pop_o && op_i.rd_en),
    .addr_i  (op_i.addr),
    .wdata_i (op_i.wdata),
    .rdata_o (rdata)
  );

  // stage and output valid flow
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_op_q <= op_i;
    end
    if (s1_move) begin
      rchar_q <= s1_op_q.rd_en ? rdata : 8'h00;
      fv_q    <= s1_op_q.frame_valid;
      done_q  <= s1_op_q.done;
      dtype_q <= s1_op_q.done_type;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_char_o     = rchar_q;
  assign frame_valid_o   = fv_q;
  assign sentence_done_o = done_q;
  assign done_type_o     = dtype_q;

endmodule

FILE: rtl/nmea_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_sentence_parser
// NMEA 0183 sentence parser with per-type field stores for GGA, RMC and GSA.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): opcode 0 transfers one received
//   byte to the parser; opcode 1 requests one stored character addressed by
//   read_type_i, read_field_i and read_pos_i.
//   Output channel (out_valid_o / out_stall_i): exactly one result per input
//   transfer, in order: read_char_o, frame_valid_o, sentence_done_o and
//   done_type_o.
//   Throughput is one item per cycle while the output is not stalled. On the
//   way to result valid, the op enters the queue at the transfer edge, then
//   the store access with registered read data follows, and then the output
//   register loads.
//   The parser updates its state at the input transfer, so later reads
//   always see earlier writes (store ops run in queue order).
//   A stall on the output backs up the output register, the store stage and
//   the 4-entry op queue; in_stall_o rises only once that queue is full.
//   Reset clears the parse state, valid flags and all pipeline valids; the
//   frame store is not cleared, and characters never written read as junk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [1:0] read_type_i,
  input  logic [4:0] read_field_i,
  input  logic [3:0] read_pos_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_char_o,
  output logic       frame_valid_o,
  output logic       sentence_done_o,
  output logic [1:0] done_type_o
);

  nsp_pkg::nsp_op_t push_op;
  nsp_pkg::nsp_op_t pop_op;
  logic             push;
  logic             pop;
  logic             fifo_full;
  logic             fifo_valid;

  nsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .read_type_i  (read_type_i),
    .read_field_i (read_field_i),
    .read_pos_i   (read_pos_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .op_o         (push_op)
  );

  nsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (pop_op)
  );

  nsp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_valid_i    (fifo_valid),
    .op_i            (pop_op),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_char_o     (read_char_o),
    .frame_valid_o   (frame_valid_o),
    .sentence_done_o (sentence_done_o),
    .done_type_o     (done_type_o)
  );

endmodule

FILE: rtl/nsp_checker.sv
// ----------------------------------------------------------------------------
// nsp_checker
// Port-level checks for the NMEA sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       opcode_i,
  input logic [7:0] rx_byte_i,
  input logic [1:0] read_type_i,
  input logic [4:0] read_field_i,
  input logic [3:0] read_pos_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_char_o,
  input logic       frame_valid_o,
  input logic       sentence_done_o,
  input logic [1:0] done_type_o
);

  // a stalled input transfer holds until accepted
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i) &&
      $stable(rx_byte_i) && $stable(read_type_i) && $stable(read_field_i) &&
      $stable(read_pos_i))
    else $error("stalled input transfer changed");

  // a finished sentence comes from a received byte, never from a read
  a_done_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_done_o |-> read_char_o == 8'h00)
    else $error("sentence_done with nonzero read_char");

  // done_type is only set together with sentence_done
  a_type_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sentence_done_o |-> done_type_o == nsp_pkg::TYPE_GGA)
    else $error("done_type set without sentence_done");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_char_o) &&
      $stable(frame_valid_o) && $stable(sentence_done_o) && $stable(done_type_o))
    else $error("stalled result changed");

endmodule

bind nmea_sentence_parser nsp_checker u_nsp_checker (.*);

FILE: verif/nmea_sentence_parser_tb.sv
// ----------------------------------------------------------------------------
// nmea_sentence_parser_tb
// Self-checking bench for the NMEA sentence parser. A short table of
// directed transfers (out-of-range reads, one good and one bad sentence,
// read-back of stored characters) is followed by random sentences with
// random content, noise, broken sentences and interleaved reads. Every
// accepted transfer runs through a local parser model. Each result is
// compared field by field against the oldest pending prediction. Both
// channels idle at random, and once the receiver holds off long enough
// to back up the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_parser_tb;

  import nsp_pkg::*;

  localparam int          RAND_ITEMS    = 1800;
  localparam int          HOLD_CYCLES   = 40;
  localparam int          STUCK_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          STORE_FIELDS  = 32;
  localparam logic [1:0]  TYPE_NONE     = 2'd3;  // no store behind this code
  localparam logic [1:0]  DONE_NONE     = 2'd0;  // done_type when nothing finished

  typedef struct packed {
    logic       op;
    logic [7:0] rx;
    logic [1:0] rt;
    logic [4:0] rf;
    logic [3:0] rp;
  } nmea_item_t;

  typedef struct packed {
    logic [7:0] rd_char;
    logic       fv;
    logic       done;
    logic [1:0] dtype;
  } parse_result_t;

  // known = 1: result typed in here, else taken from the parser model
  typedef struct packed {
    nmea_item_t    it;
    logic          known;
    parse_result_t res;
  } dir_row_t;

  localparam parse_result_t NO_RES = '0;
  localparam int            DIR_N  = 29;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // out-of-range reads right after reset
    '{'{OP_READ, 8'h00, TYPE_NONE, 5'd31, 4'd15}, 1'b1, '{8'h00, 1'b0, 1'b0, DONE_NONE}},
    '{'{OP_READ, 8'hFF, TYPE_GGA,  5'd0,  4'd0 }, 1'b1, '{8'h00, 1'b0, 1'b0, DONE_NONE}},
    // "$GPRMC,A*26" ended by a zero byte: good checksum
    '{'{OP_RX, "$", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "G", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "P", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "R", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "M", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "C", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, ",", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "A", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "*", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "2", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "6", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, 8'h00, TYPE_GGA, 5'd0, 4'd0 }, 1'b1, '{8'h00, 1'b1, 1'b1, TYPE_RMC}},
    // read back: stored char, terminator, field past the count, pos past the slots
    '{'{OP_READ, 8'h00, TYPE_RMC, 5'd1, 4'd0}, 1'b1, '{"A", 1'b1, 1'b0, DONE_NONE}},
    '{'{OP_READ, 8'h00, TYPE_RMC, 5'd1, 4'd1}, 1'b1, '{8'h00, 1'b1, 1'b0, DONE_NONE}},
    '{'{OP_READ, 8'h00, TYPE_RMC, 5'(RMC_FIELDS), 4'd0}, 1'b1,
      '{8'h00, 1'b1, 1'b0, DONE_NONE}},
    '{'{OP_READ, 8'h00, TYPE_RMC, 5'd1, 4'(FIELD_SLOTS)}, 1'b1,
      '{8'h00, 1'b1, 1'b0, DONE_NONE}},
    // "$GPGSA,*ff": lowercase digits, bad checksum, end byte all ones
    '{'{OP_RX, "$", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "G", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "P", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "G", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "S", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "A", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, ",", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "*", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, "f", TYPE_NONE, 5'd31, 4'd15}, 1'b0, NO_RES},
    '{'{OP_RX, "f", TYPE_GGA,  5'd0,  4'd0 }, 1'b0, NO_RES},
    '{'{OP_RX, 8'hFF, TYPE_NONE, 5'd31, 4'd15}, 1'b1, '{8'h00, 1'b0, 1'b1, TYPE_GSA}}
  };

  // DUT signals
  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic       opcode_i      = OP_RX;
  logic [7:0] rx_byte_i     = 8'h00;
  logic [1:0] read_type_i   = TYPE_GGA;
  logic [4:0] read_field_i  = 5'd0;
  logic [3:0] read_pos_i    = 4'd0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] read_char_o;
  logic       frame_valid_o;
  logic       sentence_done_o;
  logic [1:0] done_type_o;

  // Parser model state
  phase_e              phase_q    = PH_WAIT;
  logic [8*ID_LEN-1:0] id_q       = '0;
  int                  id_len_q   = 0;
  logic                overlong_q = 1'b0;
  logic [1:0]          type_q     = TYPE_GGA;
  logic [4:0]          fnum_q     = 5'd1;
  int                  pos_q      = 0;
  logic [7:0]          xor_q      = 8'h00;
  logic [7:0]          rsum_q     = 8'h00;
  logic [2:0]          flag_q     = 3'b000;
  logic [7:0]          store_q   [3][STORE_FIELDS][FIELD_SLOTS];
  bit                  written_q [3][STORE_FIELDS][FIELD_SLOTS];

  // Bench bookkeeping
  parse_result_t pending_results [$];
  logic [7:0]    sentence_bytes [$];
  logic [7:0]    sentence_xor;
  int            n_errors     = 0;
  int            n_results    = 0;
  int            stuck_cycles = 0;
  bit            tx_idle      = 1'b1;
  bit            rx_idle      = 1'b1;
  bit            hold_req     = 1'b0;

  nmea_sentence_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .rx_byte_i       (rx_byte_i),
    .read_type_i     (read_type_i),
    .read_field_i    (read_field_i),
    .read_pos_i      (read_pos_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_char_o     (read_char_o),
    .frame_valid_o   (frame_valid_o),
    .sentence_done_o (sentence_done_o),
    .done_type_o     (done_type_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int field_count(input logic [1:0] t);
    if (t == TYPE_GGA) return GGA_FIELDS;
    if (t == TYPE_RMC) return RMC_FIELDS;
    return GSA_FIELDS;
  endfunction

  // Store one char of the current field if it has room
  function automatic void store_char(input logic [7:0] c);
    if (fnum_q < field_count(type_q) && pos_q < FIELD_SLOTS) begin
      store_q[type_q][fnum_q][pos_q]   = c;
      written_q[type_q][fnum_q][pos_q] = 1'b1;
    end
  endfunction

  // Parser model: advances the state by one transfer, returns its result
  function automatic parse_result_t parse_step_result(input nmea_item_t it);
    parse_result_t r;
    logic [7:0]    v;
    r = '0;
    if (it.op == OP_READ) begin
      if (it.rt != TYPE_NONE) begin
        r.fv = flag_q[it.rt];
        if (it.rf >= 1 && it.rf < field_count(it.rt) && it.rp < FIELD_SLOTS)
          r.rd_char = store_q[it.rt][it.rf][it.rp];
      end
    end else begin
      case (phase_q)
        PH_WAIT: begin
          if (it.rx == CH_DOLLAR) begin
            phase_q    = PH_ID;
            id_len_q   = 0;
            overlong_q = 1'b0;
            fnum_q     = 5'd1;
            pos_q      = 0;
            xor_q      = 8'h00;
            rsum_q     = 8'h00;
          end
        end
        PH_ID: begin
          xor_q ^= it.rx;
          if (it.rx == CH_COMMA) begin
            phase_q = PH_WAIT;
            if (!overlong_q && id_len_q == ID_LEN) begin
              if (id_q == ID_GGA) begin
                type_q  = TYPE_GGA;
                phase_q = PH_FIELDS;
              end else if (id_q == ID_RMC) begin
                type_q  = TYPE_RMC;
                phase_q = PH_FIELDS;
              end else if (id_q == ID_GSA) begin
                type_q  = TYPE_GSA;
                phase_q = PH_FIELDS;
              end
            end
            pos_q = 0;
          end else if (id_len_q < ID_LEN) begin
            id_q[8*(ID_LEN-1-id_len_q) +: 8] = it.rx;
            id_len_q++;
          end else begin
            overlong_q = 1'b1;
          end
        end
        PH_FIELDS: begin
          if (it.rx == CH_COMMA) begin
            xor_q ^= it.rx;
            store_char(8'h00);
            if (fnum_q < field_count(type_q)) fnum_q++;
            pos_q = 0;
          end else if (it.rx == CH_STAR) begin
            store_char(8'h00);
            pos_q   = 0;
            phase_q = PH_SUM;
          end else begin
            xor_q ^= it.rx;
            if (pos_q < FIELD_SLOTS - 1) begin
              store_char(it.rx);
              pos_q++;
            end
          end
        end
        default: begin
          // two checksum digits, then the end byte closes the sentence
          if (pos_q >= 2) begin
            flag_q[type_q] = (rsum_q == xor_q);
            r.fv    = flag_q[type_q];
            r.done  = 1'b1;
            r.dtype = type_q;
            phase_q = PH_WAIT;
          end else begin
            if (it.rx >= CH_ZERO && it.rx <= CH_NINE) v = it.rx - HEX_DIGIT_BASE;
            else v = it.rx - HEX_ALPHA_BASE;
            if (pos_q == 0) v = v << 4;
            rsum_q = rsum_q + v;
            pos_q++;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at result %0d: %s got %0h, expected %0h", n_results, what, got, want);
    n_errors++;
  endtask

  // Offer one transfer, after a random gap if tx_idle, hold it until accepted
  task automatic transfer(input nmea_item_t it, output parse_result_t pred);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= it.op;
    rx_byte_i    <= it.rx;
    read_type_i  <= it.rt;
    read_field_i <= it.rf;
    read_pos_i   <= it.rp;
    do @(posedge clk_i); while (in_stall_o);
    pred = parse_step_result(it);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 10) return CH_ZERO + d;
    return "A" + d - 10;
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(32, 126));
    end while (c == CH_COMMA || c == CH_STAR);
    return c;
  endfunction

  function automatic void push_body(input logic [7:0] c);
    sentence_bytes.push_back(c);
    sentence_xor ^= c;
  endfunction

  // Queue one random sentence, mostly well formed, with optional noise ahead
  function automatic void build_sentence();
    int                  kind;
    int                  nf;
    int                  flen;
    logic [1:0]          t;
    logic [8*ID_LEN-1:0] id;
    logic [7:0]          sum;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) sentence_bytes.push_back(8'($urandom_range(0, 255)));
    t  = 2'($urandom_range(0, 2));
    id = (t == TYPE_GGA) ? ID_GGA : (t == TYPE_RMC) ? ID_RMC : ID_GSA;
    sentence_xor = 8'h00;
    sentence_bytes.push_back(CH_DOLLAR);
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      for (int k = 0; k < ID_LEN; k++) push_body(id[8*(ID_LEN-1-k) +: 8]);
    end else if (kind < 17) begin
      // five chars, almost never a kept ID
      repeat (ID_LEN) push_body(field_char());
    end else if (kind < 19) begin
      // overlong ID: a kept ID with extra chars
      for (int k = 0; k < ID_LEN; k++) push_body(id[8*(ID_LEN-1-k) +: 8]);
      repeat ($urandom_range(1, 3)) push_body(field_char());
    end else begin
      for (int k = 0; k < $urandom_range(0, ID_LEN - 1); k++)
        push_body(id[8*(ID_LEN-1-k) +: 8]);
    end
    push_body(CH_COMMA);
    // fields, sometimes more than the type keeps
    if ($urandom_range(0, 7) == 0) nf = $urandom_range(1, 22);
    else nf = $urandom_range(1, field_count(t) - 1);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) push_body(CH_COMMA);
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
      repeat (flen) push_body(field_char());
    end
    // broken sentence: cut before the checksum
    if ($urandom_range(0, 11) == 0) return;
    sentence_bytes.push_back(CH_STAR);
    sum  = sentence_xor;
    kind = $urandom_range(0, 9);
    if (kind == 7) sum ^= 8'($urandom_range(1, 255));
    if (kind == 9) begin
      sentence_bytes.push_back(8'($urandom_range(0, 255)));
      sentence_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      sentence_bytes.push_back(hex_char(sum[7:4]) | 8'h20);
      sentence_bytes.push_back(hex_char(sum[3:0]) | 8'h20);
    end else begin
      sentence_bytes.push_back(hex_char(sum[7:4]));
      sentence_bytes.push_back(hex_char(sum[3:0]));
    end
    // end byte is consumed whatever it is
    if ($urandom_range(0, 1) == 0) sentence_bytes.push_back(8'h0D);
    else sentence_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Random read: mostly of written chars, else some out-of-range address
  function automatic nmea_item_t random_read();
    nmea_item_t it;
    bit         found;
    it.op = OP_READ;
    it.rx = 8'($urandom);
    found = 1'b0;
    if ($urandom_range(0, 9) < 7) begin
      for (int k = 0; k < 24 && !found; k++) begin
        it.rt = 2'($urandom_range(0, 2));
        it.rf = 5'($urandom_range(1, field_count(it.rt) - 1));
        it.rp = 4'($urandom_range(0, FIELD_SLOTS - 1));
        found = written_q[it.rt][it.rf][it.rp];
      end
    end
    if (!found) begin
      it.rt = 2'($urandom_range(0, 2));
      it.rf = 5'($urandom);
      it.rp = 4'($urandom);
      case ($urandom_range(0, 3))
        0:       it.rt = TYPE_NONE;
        1:       it.rf = 5'd0;
        2:       it.rf = 5'($urandom_range(field_count(it.rt), 31));
        default: it.rp = 4'($urandom_range(FIELD_SLOTS, 15));
      endcase
    end
    return it;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, read_char", read_char_o, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (read_char_o !== want.rd_char)
          report_mismatch("read_char", read_char_o, want.rd_char);
        if (frame_valid_o !== want.fv)
          report_mismatch("frame_valid", 8'(frame_valid_o), 8'(want.fv));
        if (sentence_done_o !== want.done)
          report_mismatch("sentence_done", 8'(sentence_done_o), 8'(want.done));
        if (done_type_o !== want.dtype)
          report_mismatch("done_type", 8'(done_type_o), 8'(want.dtype));
      end
      n_results++;
    end
  end

  // Watchdog: cycles without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall before each result if rx_idle, one long hold on request
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = rx_idle ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
    end
  end

  // Sender: reset, directed table, random sentences, drain
  initial begin
    nmea_item_t    it;
    parse_result_t pred;
    int            n_items;
    bit            counts;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      transfer(DIR_TAB[i].it, pred);
      pending_results.push_back(DIR_TAB[i].known ? DIR_TAB[i].res : pred);
    end

    // back-to-back transfers into a held receiver first
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    n_items  = 0;
    while (n_items < RAND_ITEMS) begin
      build_sentence();
      while (sentence_bytes.size() > 0) begin
        if ($urandom_range(0, 5) == 0) begin
          it = random_read();
        end else begin
          it.op = OP_RX;
          it.rx = sentence_bytes.pop_front();
          it.rt = 2'($urandom);
          it.rf = 5'($urandom);
          it.rp = 4'($urandom);
        end
        // bytes dropped while waiting for a start do not count
        counts = (it.op == OP_READ) || (phase_q != PH_WAIT) || (it.rx == CH_DOLLAR);
        transfer(it, pred);
        pending_results.push_back(pred);
        if (counts) n_items++;
      end
      if (n_items > 60 && $urandom_range(0, 5) == 0) tx_idle = !tx_idle;
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
